/* src/crfp_pkg.sv */
`timescale 1ns / 1ps

package crfp_pkg;

  localparam logic [7:0] SYNC_BYTE      = 8'h55;
  localparam logic [7:0] TYPE_PHOTO_ACK = 8'h48;
  localparam logic [7:0] TYPE_INFO      = 8'h52;
  localparam logic [7:0] TYPE_PACK_ACK  = 8'h45;
  localparam logic [7:0] TYPE_PACK_DATA = 8'h46;
  localparam logic [7:0] TERM_BYTE      = 8'h23;

  localparam logic [15:0] SUM_SEED = 16'(SYNC_BYTE) + 16'(TYPE_PACK_DATA);

  localparam logic ACT_RX    = 1'b0;
  localparam logic ACT_PHOTO = 1'b1;

  localparam logic [1:0] SESS_IDLE  = 2'd0;
  localparam logic [1:0] SESS_ACKED = 2'd1;
  localparam logic [1:0] SESS_INFO  = 2'd2;

  typedef enum logic [2:0] {
    KIND_PHOTO_ACK = 3'd0,
    KIND_INFO      = 3'd1,
    KIND_PACK_ACK  = 3'd2,
    KIND_HEADER    = 3'd3,
    KIND_PAYLOAD   = 3'd4,
    KIND_SUM_GOOD  = 3'd5,
    KIND_SUM_BAD   = 3'd6,
    KIND_DROPPED   = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    PH_SYNC      = 3'd0,
    PH_TYPE      = 3'd1,
    PH_ACK_BODY  = 3'd2,
    PH_INFO_BODY = 3'd3,
    PH_PACK_BODY = 3'd4,
    PH_HEADER    = 3'd5,
    PH_PAYLOAD   = 3'd6,
    PH_SUM       = 3'd7
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] image_length;
    logic [15:0] packet_count;
    logic [15:0] packet_number;
    logic [9:0]  packet_length;
    logic [7:0]  payload;
    logic        payload_last;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_beat_t;

endpackage

/* src/crfp_intf.sv */
`timescale 1ns / 1ps

interface crfp_item_if;
  logic           valid;
  logic           ready;
  crfp_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crfp_result_if;
  logic             valid;
  logic             ready;
  crfp_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/camera_response_frame_parser_unit.sv */
`timescale 1ns / 1ps

// channel  dir  payload                                  beat when
// in_ch    in   action, rx_byte                          valid && ready
// out_ch   out  kind, image_length, packet_count,         valid && ready
//               packet_number, packet_length, payload,
//               payload_last
// cfg_ch   in   device_id                                valid && ready
//
// one byte a cycle while out_ch is not stalled; a result is registered into
// the result register as its byte moves on from the input register
// in_ch.ready drops only while both registers hold and out_ch is stalled
// cfg_ch.ready is always high; reset clears all parse and session state
// and sets device_id to zero

module camera_response_frame_parser_unit #(
  parameter int MAX_PACKET_LEN = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  crfp_item_if.sink     in_ch,
  crfp_result_if.source out_ch,
  crfp_cfg_if.sink      cfg_ch
);
  import crfp_pkg::*;

  stage_t     stage;
  res_beat_t  beat;
  logic       advance;
  logic [7:0] device_id_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= '0;
    end else if (cfg_ch.valid) begin
      device_id_q <= cfg_ch.data;
    end
  end

  crfp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .advance_i (advance),
    .stage_o   (stage)
  );

  crfp_parser #(
    .MAX_PACKET_LEN (MAX_PACKET_LEN)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .advance_i   (advance),
    .device_id_i (device_id_q),
    .beat_o      (beat)
  );

  crfp_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .advance_o (advance),
    .out_ch    (out_ch)
  );

endmodule

/* src/crfp_in_stage.sv */
`timescale 1ns / 1ps

module crfp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  crfp_item_if.sink         in_ch,
  input  logic              advance_i,
  output crfp_pkg::stage_t  stage_o
);
  import crfp_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  assign in_ch.ready = !vld_q || advance_i;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_ch.data;
    end
  end

  assign stage_o.valid = vld_q;
  assign stage_o.item  = item_q;

endmodule

/* src/crfp_parser.sv */
`timescale 1ns / 1ps

module crfp_parser #(
  parameter int MAX_PACKET_LEN = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crfp_pkg::stage_t    stage_i,
  input  logic                advance_i,
  input  logic [7:0]          device_id_i,
  output crfp_pkg::res_beat_t beat_o
);
  import crfp_pkg::*;

  phase_e          phase_q, phase_d;
  logic [9:0]      idx_q, idx_d;
  logic [15:0]     run_q, run_d;
  logic [15:0]     lat_q, lat_d;
  logic [1:0]      sess_q, sess_d;
  logic [9:0]      len_q, len_d;
  logic [15:0]     num_q, num_d;
  logic [5:0][7:0] fa_q, fa_d;
  logic            id_ok_q, id_ok_d;

  logic        consume;
  logic [7:0]  b;
  logic [2:0]  slot;
  logic [15:0] len16;
  logic [15:0] run_next;
  logic [9:0]  idx_inc;
  logic        last;
  logic [15:0] got;
  logic        emit;
  result_t     res;

  assign consume = stage_i.valid && advance_i;
  assign b       = stage_i.item.rx_byte;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    run_d    = run_q;
    lat_d    = lat_q;
    sess_d   = sess_q;
    len_d    = len_q;
    num_d    = num_q;
    fa_d     = fa_q;
    id_ok_d  = id_ok_q;
    emit     = 1'b0;
    res      = '0;
    slot     = '0;
    len16    = '0;
    run_next = run_q + 16'(b);
    idx_inc  = idx_q + 10'd1;
    last     = 1'b0;
    got      = {b, fa_q[0]};
    if (consume) begin
      if (stage_i.item.action == ACT_PHOTO) begin
        sess_d = SESS_IDLE;
      end else begin
        case (phase_q)
          PH_SYNC: begin
            if (b == SYNC_BYTE) begin
              phase_d = PH_TYPE;
              idx_d   = '0;
            end
          end
          PH_TYPE: begin
            idx_d   = '0;
            fa_d    = '0;
            id_ok_d = 1'b0;
            if (b == TYPE_PHOTO_ACK) begin
              phase_d = PH_ACK_BODY;
            end else if (b == TYPE_INFO && sess_q == SESS_ACKED) begin
              phase_d = PH_INFO_BODY;
            end else if (b == TYPE_PACK_ACK && sess_q == SESS_INFO) begin
              phase_d = PH_PACK_BODY;
            end else if (b == TYPE_PACK_DATA && sess_q == SESS_INFO) begin
              phase_d = PH_HEADER;
              run_d   = SUM_SEED;
            end
          end
          PH_ACK_BODY, PH_PACK_BODY: begin
            if (idx_q == '0) begin
              id_ok_d = (b == device_id_i);
              idx_d   = 10'd1;
            end else begin
              phase_d = PH_SYNC;
              idx_d   = '0;
              emit    = 1'b1;
              if (!id_ok_q || b != TERM_BYTE) begin
                res.kind = KIND_DROPPED;
              end else if (phase_q == PH_ACK_BODY) begin
                sess_d   = SESS_ACKED;
                res.kind = KIND_PHOTO_ACK;
              end else begin
                res.kind = KIND_PACK_ACK;
              end
            end
          end
          PH_INFO_BODY: begin
            if (idx_q == '0) begin
              id_ok_d = (b == device_id_i);
              idx_d   = 10'd1;
            end else if (idx_q <= 10'd6) begin
              slot       = idx_q[2:0] - 3'd1;
              fa_d[slot] = b;
              idx_d      = idx_inc;
            end else begin
              phase_d = PH_SYNC;
              idx_d   = '0;
              emit    = 1'b1;
              if (!id_ok_q || b != TERM_BYTE) begin
                res.kind = KIND_DROPPED;
              end else begin
                sess_d           = SESS_INFO;
                res.kind         = KIND_INFO;
                res.image_length = {fa_q[3], fa_q[2], fa_q[1], fa_q[0]};
                res.packet_count = {fa_q[5], fa_q[4]};
              end
            end
          end
          PH_HEADER: begin
            run_d = run_next;
            if (idx_q == '0) begin
              id_ok_d = (b == device_id_i);
              idx_d   = 10'd1;
            end else begin
              slot       = {1'b0, 2'(idx_q[1:0] - 2'd1)};
              fa_d[slot] = b;
              len16      = {fa_d[3], fa_d[2]};
              if (idx_q < 10'd4) begin
                idx_d = idx_inc;
              end else begin
                idx_d = '0;
                emit  = 1'b1;
                if (!id_ok_q || len16 > 16'(MAX_PACKET_LEN)) begin
                  phase_d  = PH_SYNC;
                  res.kind = KIND_DROPPED;
                end else begin
                  num_d             = {fa_d[1], fa_d[0]};
                  len_d             = len16[9:0];
                  res.kind          = KIND_HEADER;
                  res.packet_number = {fa_d[1], fa_d[0]};
                  res.packet_length = len16[9:0];
                  if (len16[9:0] == '0) begin
                    lat_d   = run_next;
                    phase_d = PH_SUM;
                  end else begin
                    phase_d = PH_PAYLOAD;
                  end
                end
              end
            end
          end
          PH_PAYLOAD: begin
            run_d = run_next;
            idx_d = idx_inc;
            last  = (idx_inc >= len_q);
            if (last) begin
              lat_d   = run_next;
              phase_d = PH_SUM;
              idx_d   = '0;
            end
            emit             = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload      = b;
            res.payload_last = last;
          end
          PH_SUM: begin
            if (idx_q == '0) begin
              fa_d    = '0;
              fa_d[0] = b;
              idx_d   = 10'd1;
            end else begin
              phase_d           = PH_SYNC;
              idx_d             = '0;
              emit              = 1'b1;
              res.kind          = (got == lat_q) ? KIND_SUM_GOOD : KIND_SUM_BAD;
              res.packet_number = num_q;
            end
          end
          default: begin
            phase_d = PH_SYNC;
          end
        endcase
      end
    end
    beat_o.valid = emit;
    beat_o.res   = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC;
      idx_q   <= '0;
      run_q   <= '0;
      lat_q   <= '0;
      sess_q  <= SESS_IDLE;
      len_q   <= '0;
      num_q   <= '0;
      fa_q    <= '0;
      id_ok_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      run_q   <= run_d;
      lat_q   <= lat_d;
      sess_q  <= sess_d;
      len_q   <= len_d;
      num_q   <= num_d;
      fa_q    <= fa_d;
      id_ok_q <= id_ok_d;
    end
  end

endmodule

/* src/crfp_out_stage.sv */
`timescale 1ns / 1ps

module crfp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crfp_pkg::res_beat_t beat_i,
  output logic                advance_o,
  crfp_result_if.source       out_ch
);
  import crfp_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign advance_o = !vld_q || out_ch.ready;
  assign vld_d     = advance_o ? beat_i.valid : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && beat_i.valid) begin
      res_q <= beat_i.res;
    end
  end

  assign out_ch.valid = vld_q;
  assign out_ch.data  = res_q;

endmodule

/* src/crfp_checker.sv */
`timescale 1ns / 1ps

module crfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_kind_i,
  input logic [15:0] out_number_i,
  input logic [9:0]  out_length_i,
  input logic        out_last_i
);
  import crfp_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // with the result register empty the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_kind_i == KIND_PAYLOAD)
    else $error("last flag on a non-payload beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != KIND_HEADER |-> out_length_i == '0)
    else $error("packet length outside header beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_INFO || out_kind_i == KIND_PAYLOAD ||
    out_kind_i == KIND_DROPPED) |-> out_number_i == '0)
    else $error("packet number on wrong beat kind");

endmodule

bind camera_response_frame_parser_unit crfp_checker u_crfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_kind_i   (out_ch.data.kind),
  .out_number_i (out_ch.data.packet_number),
  .out_length_i (out_ch.data.packet_length),
  .out_last_i   (out_ch.data.payload_last)
);
